/* sv/rpc_pkg.sv */
// Shared types, opcode and register codes, and divide helpers for the
// RGBA pixel compositing unit. No dependencies.
package rpc_pkg;

  // Opcodes
  localparam logic [1:0] OP_BLEND = 2'd0;
  localparam logic [1:0] OP_TINT  = 2'd1;
  localparam logic [1:0] OP_CONST = 2'd2;
  localparam logic [1:0] OP_GREY  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_TINT_RED   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TINT_GREEN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TINT_BLUE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TINT_ALPHA = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GREY_AMT   = 3'd4;

  localparam logic [7:0] FULL = 8'd255;

  // Lane 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][7:0]  lanes8_t;
  typedef logic [3:0][15:0] lanes16_t;

  typedef struct packed {
    logic [7:0] tint_red;
    logic [7:0] tint_green;
    logic [7:0] tint_blue;
    logic [7:0] tint_alpha;
    logic [7:0] grey_amount;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    lanes8_t    dst;
    lanes8_t    src;
  } in_t;

  // Front end result: pixel plus effective alpha and grey level
  typedef struct packed {
    logic [1:0] op;
    lanes8_t    dst;
    lanes8_t    src;
    logic [7:0] eff_a;
    logic [7:0] grey;
  } mid_t;

  // Back end result: first term and product still to be scaled
  typedef struct packed {
    lanes8_t  q1;
    lanes16_t p3;
  } fin_t;

  // x / 255 by multiplying with 32897 / 2^23 (shift-add).
  // Exact for every x up to 65279; callers stay within 255*255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [31:0] acc;
    acc = {1'b0, x, 15'd0} + {9'd0, x, 7'd0} + {16'd0, x};
    return acc[30:23];
  endfunction

  // x / 3 by multiplying with 683 / 2^11, exact for x below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] acc;
    acc = {1'b0, x, 9'd0} + {3'd0, x, 7'd0} + {5'd0, x, 5'd0}
        + {7'd0, x, 3'd0} + {9'd0, x, 1'b0} + {10'd0, x};
    return acc[18:11];
  endfunction

endpackage

/* sv/rpc_front.sv */
// Front end of the compositing pipeline: input register, effective alpha
// and grey sum, then their divides. Depends on rpc_pkg.
module rpc_front import rpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output mid_t out_data_o
);

  logic va_q, vb_q, vc_q;
  logic en_a, en_b, en_c;

  in_t         a_q;
  in_t         b_q;
  logic [15:0] pe_d, pe_q;
  logic [9:0]  gsum_d, gsum_q;
  mid_t        c_d, c_q;

  // Advance a stage when it is empty or its successor advances
  assign en_c = !vc_q || out_ready_i;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign in_ready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  // Source alpha times tint alpha, and the sum of the three colors
  always_comb begin
    pe_d   = 16'(a_q.src[3]) * 16'(cfg_i.tint_alpha);
    gsum_d = 10'(a_q.dst[0]) + 10'(a_q.dst[1]) + 10'(a_q.dst[2]);
  end

  // Scale both down
  always_comb begin
    c_d.op    = b_q.op;
    c_d.dst   = b_q.dst;
    c_d.src   = b_q.src;
    c_d.eff_a = div255(pe_q);
    c_d.grey  = div3(gsum_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_a) a_q <= in_data_i;
    if (en_b) begin
      b_q    <= a_q;
      pe_q   <= pe_d;
      gsum_q <= gsum_d;
    end
    if (en_c) c_q <= c_d;
  end

  assign out_valid_o = vc_q;
  assign out_data_o  = c_q;

endmodule

/* sv/rpc_blend.sv */
// Blend core: per-lane products, their divides by 255, and the tint
// product for the tinted blend. Depends on rpc_pkg.
module rpc_blend import rpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  mid_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output fin_t out_data_o
);

  logic vd_q, ve_q, vf_q;
  logic en_d, en_e, en_f;

  lanes16_t   p1_d, p1_q, p2_d, p2_q;
  logic [1:0] op_d_q, op_e_q;
  lanes8_t    q1_d, q1_q, q2_d, q2_q;
  fin_t       f_d, f_q;
  lanes8_t    tint;

  assign tint = {FULL, cfg_i.tint_blue, cfg_i.tint_green, cfg_i.tint_red};

  // Advance a stage when it is empty or its successor advances
  assign en_f = !vf_q || out_ready_i;
  assign en_e = !ve_q || en_f;
  assign en_d = !vd_q || en_e;
  assign in_ready_o = en_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      if (en_d) vd_q <= in_valid_i;
      if (en_e) ve_q <= vd_q;
      if (en_f) vf_q <= ve_q;
    end
  end

  // Pick the two product operand pairs of each lane by opcode
  always_comb begin
    logic [7:0] a1, b1, a2, b2;
    for (int l = 0; l < 4; l++) begin
      a1 = in_data_i.dst[l];
      b1 = FULL;
      a2 = 8'd0;
      b2 = 8'd0;
      case (in_data_i.op)
        OP_BLEND: begin
          b1 = FULL - in_data_i.src[3];
          a2 = in_data_i.src[l];
          b2 = in_data_i.src[3];
        end
        OP_TINT: begin
          if (l < 3) begin
            b1 = FULL - in_data_i.eff_a;
            a2 = in_data_i.src[l];
            b2 = in_data_i.eff_a;
          end else begin
            // output alpha is full
            a1 = FULL;
          end
        end
        OP_CONST: begin
          if (l < 3) begin
            b1 = FULL - cfg_i.tint_alpha;
            a2 = tint[l];
            b2 = cfg_i.tint_alpha;
          end
        end
        default: begin
          if (l < 3) begin
            b1 = FULL - cfg_i.grey_amount;
            a2 = in_data_i.grey;
            b2 = cfg_i.grey_amount;
          end
        end
      endcase
      p1_d[l] = 16'(a1) * 16'(b1);
      p2_d[l] = 16'(a2) * 16'(b2);
    end
  end

  // Divide by 255; greyscale sums its two products first
  always_comb begin
    logic [16:0] psum;
    for (int l = 0; l < 4; l++) begin
      psum = 17'(p1_q[l]) + 17'(p2_q[l]);
      if (op_d_q == OP_GREY) begin
        q1_d[l] = div255(psum[15:0]);
        q2_d[l] = 8'd0;
      end else begin
        q1_d[l] = div255(p1_q[l]);
        q2_d[l] = div255(p2_q[l]);
      end
    end
  end

  // Scale the color term by the tint, or by full weight to keep it
  always_comb begin
    logic [7:0] k;
    f_d.q1 = q1_q;
    for (int l = 0; l < 4; l++) begin
      k = (op_e_q == OP_TINT) ? tint[l] : FULL;
      f_d.p3[l] = 16'(q2_q[l]) * 16'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      op_d_q <= in_data_i.op;
    end
    if (en_e) begin
      q1_q   <= q1_d;
      q2_q   <= q2_d;
      op_e_q <= op_d_q;
    end
    if (en_f) f_q <= f_d;
  end

  assign out_valid_o = vf_q;
  assign out_data_o  = f_q;

  // A stalled result holds its place and value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vf_q && !out_ready_i) |=> (vf_q && $stable(f_q)))
    else $error("blend result changed while stalled");

  // Greyscale leaves no second term to scale
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd_q && en_e && op_d_q == OP_GREY) |=> (q2_q == '0))
    else $error("greyscale second term not zero");

endmodule

/* sv/rpc_out.sv */
// Output stage: final divide and add, and the result register toward the
// master side. Depends on rpc_pkg.
module rpc_out import rpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  fin_t    in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output lanes8_t out_data_o
);

  logic    v_q;
  logic    en;
  lanes8_t res_d, res_q;

  assign en = !v_q || out_ready_i;
  assign in_ready_o = en;

  // Sums stay within 255, so drop the carry
  always_comb begin
    logic [8:0] sum;
    for (int l = 0; l < 4; l++) begin
      sum = 9'(in_data_i.q1[l]) + 9'(div255(in_data_i.p3[l]));
      res_d[l] = sum[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = res_q;

endmodule

/* sv/rgba_pixel_composite_unit.sv */
// Top level of the RGBA pixel compositing unit: configuration registers and
// the front, blend and output pipeline parts. Depends on rpc_pkg.
//
// The unit takes one pixel transfer per clock, unless backpressure has filled
// every stage, and returns one result pixel per input, in order. Seven
// register stages (input, alpha product, divides, lane products, divides,
// tint product, result) lie between input and output; the multiplies and
// the divides by 255 and by 3 sit in them, the divides done as constant
// shift-adds. Backpressure on the master side stalls the stages in turn and
// fills bubbles first, so an input keeps being taken while free stages
// remain. Write the configuration registers only while no pixel is in
// flight; writes to indexes past the grey amount are ignored.
module rgba_pixel_composite_unit import rpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  // Pixel input
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // dst_red, dst_green, dst_blue, dst_alpha, src_red, src_green, src_blue,
  // src_alpha
  input  logic [63:0]        s_axis_tdata,
  // opcode
  input  logic [1:0]         s_axis_tuser,
  // Pixel result
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0]        m_axis_tdata
);

  cfg_t    cfg_d, cfg_q;
  in_t     in_item;
  mid_t    mid_data;
  fin_t    fin_data;
  lanes8_t res;
  logic    mid_valid, mid_ready, fin_valid, fin_ready;

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TINT_RED:   cfg_d.tint_red    = cfg_wdata_i;
        CFG_TINT_GREEN: cfg_d.tint_green  = cfg_wdata_i;
        CFG_TINT_BLUE:  cfg_d.tint_blue   = cfg_wdata_i;
        CFG_TINT_ALPHA: cfg_d.tint_alpha  = cfg_wdata_i;
        CFG_GREY_AMT:   cfg_d.grey_amount = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tint_red: FULL, tint_green: FULL, tint_blue: FULL,
                 tint_alpha: FULL, grey_amount: FULL};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Unpack the input transfer
  assign in_item.op  = s_axis_tuser;
  assign in_item.dst = s_axis_tdata[31:0];
  assign in_item.src = s_axis_tdata[63:32];

  rpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_item),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_data_o  (mid_data)
  );

  rpc_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_data),
    .out_valid_o (fin_valid),
    .out_ready_i (fin_ready),
    .out_data_o  (fin_data)
  );

  rpc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fin_valid),
    .in_ready_o  (fin_ready),
    .in_data_i   (fin_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = res;

  // An open output lets every stage advance, so the input is ready
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

  // A cycle in reset leaves no result offered at the next edge
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule
